FILE: sv/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte hasher.
// No dependencies; every other file imports this package.
package sha_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // One 512-bit block request for the compression core; words[0] is the first word.
  typedef struct packed {
    logic [15:0][31:0] words;
    logic              fin;
  } sha_blk_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: sv/sha_front.sv
// Front end: packs message bytes into blocks and builds the padded final block(s).
// Depends on sha_pkg.
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              push,
  output sha_pkg::sha_blk_t push_data,
  input  logic              full
);
  import sha_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_PAD2 = 2'd2;

  logic [1:0]        state;
  logic [15:0][31:0] blk;
  logic [15:0][31:0] blk_next;
  logic [15:0][31:0] pad_words;
  logic [5:0]        fill;
  logic [63:0]       bit_len;
  logic              acc;
  logic              fits;

  assign in_stall = (state != ST_IDLE) || full;
  assign acc      = in_valid && !in_stall;
  assign fits     = (fill <= 6'd55);

  // Buffer with the incoming byte dropped into its slot.
  always_comb begin
    blk_next = blk;
    blk_next[fill[5:2]][8*(3 - fill[1:0]) +: 8] = in_data.msg_byte;
  end

  // Data bytes below fill, 0x80 at fill, zeros above; length in the last two words if fill <= 55.
  always_comb begin
    for (int p = 0; p < 64; p++) begin
      if (6'(p) < fill) begin
        pad_words[p/4][31 - 8*(p%4) -: 8] = blk[p/4][31 - 8*(p%4) -: 8];
      end else if (6'(p) == fill) begin
        pad_words[p/4][31 - 8*(p%4) -: 8] = 8'h80;
      end else begin
        pad_words[p/4][31 - 8*(p%4) -: 8] = 8'h00;
      end
    end
    if (fits) begin
      pad_words[14] = bit_len[63:32];
      pad_words[15] = bit_len[31:0];
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '{words: blk_next, fin: 1'b0};
    case (state)
      ST_IDLE: begin
        push = acc && in_data.byte_valid && (fill == 6'd63);
      end
      ST_PAD: begin
        push      = !full;
        push_data = '{words: pad_words, fin: fits};
      end
      ST_PAD2: begin
        push            = !full;
        push_data.words = '0;
        push_data.words[14] = bit_len[63:32];
        push_data.words[15] = bit_len[31:0];
        push_data.fin   = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      bit_len <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (in_data.byte_valid) begin
              blk     <= blk_next;
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
            if (in_data.last_byte) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!full) begin
            if (fits) begin
              fill    <= '0;
              bit_len <= '0;
              state   <= ST_IDLE;
            end else begin
              state <= ST_PAD2;
            end
          end
        end
        ST_PAD2: begin
          if (!full) begin
            fill    <= '0;
            bit_len <= '0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sha_fifo.sv
// Small register queue of block requests between front end and core.
// Depends on sha_pkg.
module sha_fifo #(
  parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha_pkg::sha_blk_t push_data,
  output logic              full,
  input  logic              pop,
  output sha_pkg::sha_blk_t pop_data,
  output logic              empty
);
  import sha_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sha_blk_t        q [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = q[rp];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

FILE: sv/sha_core.sv
// Back end: 64-round compression, one round per cycle, and digest output.
// Depends on sha_pkg.
module sha_core (
  input  logic              clk,
  input  logic              rst,
  output logic              pop,
  input  sha_pkg::sha_blk_t pop_data,
  input  logic              empty,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [15:0][31:0] win;
  logic [7:0][31:0]  v;
  logic [7:0][31:0]  cv;
  logic [5:0]        t;
  logic [2:0]        oidx;
  logic              fin;
  logic [31:0]       w_new;
  logic [31:0]       t1;
  logic [31:0]       t2;

  assign pop = (state == ST_IDLE) && !empty;

  // Window holds W[t..t+15], win[0] is the current word.
  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t) + win[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign out_valid            = (state == ST_OUT);
  assign out_data.digest_word = cv[oidx];
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      t     <= '0;
      oidx  <= '0;
      for (int i = 0; i < 8; i++) begin
        cv[i] <= iv_word(3'(i));
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            win   <= pop_data.words;
            fin   <= pop_data.fin;
            v     <= cv;
            t     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          win  <= {w_new, win[15:1]};
          v    <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
          t    <= t + 6'd1;
          if (t == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            cv[i] <= cv[i] + v[i];
          end
          state <= fin ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (oidx == 3'd7) begin
              oidx  <= '0;
              state <= ST_IDLE;
              for (int i = 0; i < 8; i++) begin
                cv[i] <= iv_word(3'(i));
              end
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: front end, block queue and compression core.
// Bytes are taken one per cycle while in_stall is low; each 64-byte block passes
// through the core as load, 64 rounds and chaining add, so the speed on a long
// message is set by the single round unit. Final pad adds one or two blocks, then
// eight digest words follow, one per cycle while out_stall is low. Synchronous
// reset clears all control state and loads the initial hash values.
module sha256_byte_stream_hasher #(
  parameter int unsigned QDEPTH = sha_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  // Block requests from the front end to the core.
  sha_blk_t push_data;
  sha_blk_t pop_data;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  // Front end stalls the input only while padding or when the queue is full.
  sha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue decouples byte packing from the 64-round compression.
  sha_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Core compresses blocks and drives the digest words on the final one.
  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sim/sha256_byte_stream_hasher_test.sv
// Testbench for sha256_byte_stream_hasher: a directed table of messages, then random ones.
// Every digest word is checked against a SHA-256 predictor in this file. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandomItems = 40;
  localparam int unsigned PadLens [5] = '{55, 56, 63, 64, 119};

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sha_out_t out_data;

  sha256_byte_stream_hasher DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Standard constants, kept here so the predictor does not lean on the package.
  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Predictor state
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;
  logic [5:0]  slot;

  sha_out_t digest_q [$];
  int unsigned errors;
  int unsigned cycles;

  function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, a15, a2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        a15 = w[(t - 15) & 15];
        a2  = w[(t - 2) & 15];
        wt = w[t & 15] + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + w[(t - 7) & 15]
             + (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10));
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic pack_byte(logic [7:0] b);
    if (slot[1:0] == 2'd0) blk[slot[5:2]] = '0;
    blk[slot[5:2]] |= 32'(b) << (24 - 8 * slot[1:0]);
    slot++;
  endtask

  // Runs one accepted request through the predictor; an end of message queues eight words.
  task automatic hash_request(sha_in_t r);
    if (r.byte_valid) begin
      pack_byte(r.msg_byte);
      msg_bits += 64'd8;
      if (slot == 0) compress_block();
    end
    if (r.last_byte) begin
      pack_byte(8'h80);
      if (slot == 0) begin
        compress_block();
      end else if (slot > 56) begin
        while (slot != 0) pack_byte(8'h00);
        compress_block();
      end
      while (slot < 56) pack_byte(8'h00);
      blk[14] = msg_bits[63:32];
      blk[15] = msg_bits[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
      for (int i = 0; i < 8; i++) chain[i] = HashInit[i];
      msg_bits = '0;
      slot = '0;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall per word, compare at the rising edge.
  initial begin
    int unsigned hold;
    sha_out_t want;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      out_stall = 1'b1;
      repeat (hold) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_data), '0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", 64'(out_data.digest_word), 64'(want.digest_word));
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 64'(out_data.word_index), 64'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 64'(out_data.last_word), 64'(want.last_word));
      end
      @(negedge clk);
    end
  end

  // Request side
  task automatic send_request(sha_in_t r);
    int unsigned gap;
    gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0) gap = 0;
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_data  = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    hash_request(r);
    @(negedge clk);
  endtask

  // Directed table: byte, byte_valid, last_byte, expected first digest word (0 = predicted only).
  typedef struct {
    logic [7:0]  b;
    logic        bv;
    logic        lb;
    logic [31:0] word0;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    sha_in_t r;
    int unsigned len, n_items;
    dir_row_t row;
    in_valid = 1'b0;
    in_data  = '0;
    rst      = 1'b1;
    for (int i = 0; i < 8; i++) chain[i] = HashInit[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    msg_bits = '0;
    slot = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty message, end marker with no byte: well-known digest e3b0c442...
    dir_rows.push_back('{8'h00, 1'b0, 1'b1, 32'he3b0c442});
    // Ignored item, then "abc" ending on a byte: ba7816bf...
    dir_rows.push_back('{8'hff, 1'b0, 1'b0, 32'h0});
    dir_rows.push_back('{8'h61, 1'b1, 1'b0, 32'h0});
    dir_rows.push_back('{8'h62, 1'b1, 1'b0, 32'h0});
    dir_rows.push_back('{8'h63, 1'b1, 1'b1, 32'hba7816bf});
    // Field extremes: single 0x00 and single 0xff messages.
    dir_rows.push_back('{8'h00, 1'b1, 1'b1, 32'h0});
    dir_rows.push_back('{8'hff, 1'b1, 1'b1, 32'h0});
    // Two bytes then end marker with no byte.
    dir_rows.push_back('{8'h5a, 1'b1, 1'b0, 32'h0});
    dir_rows.push_back('{8'ha5, 1'b1, 1'b0, 32'h0});
    dir_rows.push_back('{8'h00, 1'b0, 1'b1, 32'h0});
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_request('{row.b, row.bv, row.lb});
      if (row.word0 != 0 && digest_q.size() >= 8 && digest_q[digest_q.size() - 8].digest_word
          !== row.word0)
        report_mismatch("table digest", 64'(digest_q[digest_q.size() - 8].digest_word),
                        64'(row.word0));
    end

    // Lengths around the pad boundary: pad fits, pad does not fit, exact block.
    for (int k = 0; k < 5; k++) begin
      len = PadLens[k];
      for (int i = 0; i < len; i++) begin
        r = '{8'($urandom), 1'b1, i == len - 1};
        send_request(r);
      end
    end
    // Exact block, then end with no byte.
    for (int i = 0; i < 64; i++) send_request('{8'($urandom), 1'b1, 1'b0});
    send_request('{8'h00, 1'b0, 1'b1});

    // Random messages: mostly short, with noise items mixed in.
    n_items = 0;
    while (n_items < RandomItems) begin
      len = $urandom_range(0, 7) == 0 ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if (n_items + len > RandomItems) len = RandomItems - n_items;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request('{8'($urandom), 1'b0, 1'b0});
          n_items++;
        end
        send_request('{8'($urandom), 1'b1, 1'b0});
        n_items++;
      end
      if ($urandom_range(0, 1) == 0) send_request('{8'($urandom), 1'b1, 1'b1});
      else send_request('{8'($urandom), 1'b0, 1'b1});
      n_items++;
    end
    in_valid = 1'b0;

    while (digest_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_fifo.sv
sv/sha_core.sv
sv/sha256_byte_stream_hasher.sv
sim/sha256_byte_stream_hasher_test.sv
